### rtl/core/lsm_pkg.sv
// ----------------------------------------------------------------------------
// lsm_pkg
// Shared types and constants for the linear sieve with Moebius output.
// ----------------------------------------------------------------------------
package lsm_pkg;

  // Width of a number on the ports and in the prime list
  localparam int NUM_W = 15;
  // Running number can sit one above the largest limit
  localparam int CUR_W = NUM_W + 1;
  localparam int NUM_MAX = (1 << NUM_W) - 1;
  localparam int PROD_W = 2 * NUM_W;

  localparam int MAX_NUMBER_DEF = 32768;
  localparam int PRIME_SLOTS_DEF = 4096;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [NUM_W-1:0] LIMIT_RESET = 15'd20001;

  // Moebius codes, two's complement
  localparam logic signed [1:0] MU_ZERO = 2'sb00;
  localparam logic signed [1:0] MU_ONE = 2'sb01;
  localparam logic signed [1:0] MU_MINUS_ONE = 2'sb11;

  // How the back end has to treat a queued beat
  typedef enum logic [1:0] {
    KIND_DONE   = 2'd0,
    KIND_ONE    = 2'd1,
    KIND_NUMBER = 2'd2
  } kind_t;

  typedef struct packed {
    logic             clear;
    kind_t            kind;
    logic [NUM_W-1:0] number;
    logic [NUM_W-1:0] top;
  } item_t;

  typedef struct packed {
    logic done;
    logic divisible;
  } rem_stat_t;

endpackage

### rtl/core/lsm_front.sv
// ----------------------------------------------------------------------------
// lsm_front
// Holds the limit register and the running number, accepts request beats
// and classifies each one for the back end.
// ----------------------------------------------------------------------------
module lsm_front #(
  parameter int MAX_NUMBER = lsm_pkg::MAX_NUMBER_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lsm_pkg::NUM_W-1:0] limit,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      restart,
  input  logic                      q_full,
  input  logic                      clearing,
  output logic                      q_push,
  output lsm_pkg::item_t            q_item
);

  localparam int TOP_CAP = (MAX_NUMBER - 1 > lsm_pkg::NUM_MAX) ? lsm_pkg::NUM_MAX
                                                                : MAX_NUMBER - 1;

  logic [lsm_pkg::NUM_W-1:0] top_limit;
  logic [lsm_pkg::NUM_W-1:0] top;
  logic [lsm_pkg::CUR_W-1:0] current_number;
  logic [lsm_pkg::CUR_W-1:0] n;
  logic                      done;
  lsm_pkg::kind_t            kind;

  assign cfg_ready = 1'b1;

  always_comb begin
    top = (top_limit > lsm_pkg::NUM_W'(TOP_CAP)) ? lsm_pkg::NUM_W'(TOP_CAP) : top_limit;
    n = restart ? lsm_pkg::CUR_W'(1) : current_number;
    done = n > lsm_pkg::CUR_W'(top);
    priority if (done) begin
      kind = lsm_pkg::KIND_DONE;
    end else if (n == lsm_pkg::CUR_W'(1)) begin
      kind = lsm_pkg::KIND_ONE;
    end else begin
      kind = lsm_pkg::KIND_NUMBER;
    end
  end

  assign in_stall = q_full || clearing;
  assign q_push = in_valid && !in_stall;
  assign q_item = '{clear: restart, kind: kind, number: n[lsm_pkg::NUM_W-1:0], top: top};

  always_ff @(posedge clk) begin
    if (rst) begin
      top_limit <= lsm_pkg::LIMIT_RESET;
      current_number <= lsm_pkg::CUR_W'(1);
    end else begin
      if (cfg_valid) begin
        top_limit <= limit;
      end
      // past the limit the number holds; done until restart or a limit above it
      if (q_push) begin
        current_number <= done ? n : n + lsm_pkg::CUR_W'(1);
      end
    end
  end

endmodule

### rtl/core/lsm_queue.sv
// ----------------------------------------------------------------------------
// lsm_queue
// Short register queue between front and back end.
// ----------------------------------------------------------------------------
module lsm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lsm_pkg::item_t item_in,
  input  logic           pop,
  output lsm_pkg::item_t item_out,
  output logic           full,
  output logic           empty
);

  localparam int QW = (lsm_pkg::QUEUE_DEPTH > 1) ? $clog2(lsm_pkg::QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(lsm_pkg::QUEUE_DEPTH + 1);

  lsm_pkg::item_t slots [lsm_pkg::QUEUE_DEPTH];
  logic [QW-1:0]  wr_ptr;
  logic [QW-1:0]  rd_ptr;
  logic [QCW-1:0] fill;

  assign full = fill == QCW'(lsm_pkg::QUEUE_DEPTH);
  assign empty = fill == '0;
  assign item_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QW'(lsm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QW'(lsm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QW'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCW'(1);
      end else if (pop && !push) begin
        fill <= fill - QCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

endmodule

### rtl/core/lsm_rem.sv
// ----------------------------------------------------------------------------
// lsm_rem
// Bit-serial restoring remainder unit; reports whether divisor divides
// dividend, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsm_rem (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [lsm_pkg::NUM_W-1:0] dividend,
  input  logic [lsm_pkg::NUM_W-1:0] divisor,
  output lsm_pkg::rem_stat_t        stat
);

  localparam int CW = $clog2(lsm_pkg::NUM_W);

  logic                      busy;
  logic                      done;
  logic                      divisible;
  logic [CW-1:0]             cnt;
  logic [lsm_pkg::NUM_W-1:0] rem;
  logic [lsm_pkg::NUM_W-1:0] dvd;
  logic [lsm_pkg::NUM_W-1:0] dvs;
  logic [lsm_pkg::NUM_W:0]   rem_sh;
  logic [lsm_pkg::NUM_W-1:0] rem_next;
  logic                      last;

  always_comb begin
    rem_sh = {rem, dvd[lsm_pkg::NUM_W-1]};
    if (rem_sh >= {1'b0, dvs}) begin
      rem_next = lsm_pkg::NUM_W'(rem_sh - {1'b0, dvs});
    end else begin
      rem_next = lsm_pkg::NUM_W'(rem_sh);
    end
  end

  assign last = cnt == CW'(lsm_pkg::NUM_W - 1);
  assign stat = '{done: done, divisible: divisible};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && last) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dvs <= divisor;
      cnt <= '0;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[lsm_pkg::NUM_W-2:0], 1'b0};
      cnt <= cnt + CW'(1);
      if (last) begin
        divisible <= rem_next == '0;
      end
    end
  end

endmodule

### rtl/core/lsm_back.sv
// ----------------------------------------------------------------------------
// lsm_back
// Sieve engine: composite bitmap, Moebius store and prime list, the walk
// over the primes for each number, and the result register.
// ----------------------------------------------------------------------------
module lsm_back #(
  parameter int MAX_NUMBER  = lsm_pkg::MAX_NUMBER_DEF,
  parameter int PRIME_SLOTS = lsm_pkg::PRIME_SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lsm_pkg::item_t            q_item,
  input  logic                      q_empty,
  output logic                      q_pop,
  output logic                      clearing,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [lsm_pkg::NUM_W-1:0] number,
  output logic                      is_prime,
  output logic signed [1:0]         mobius,
  output logic                      done_res
);

  localparam int AW = $clog2(MAX_NUMBER);
  localparam int PIW = $clog2(PRIME_SLOTS);
  localparam int PCW = $clog2(PRIME_SLOTS + 1);
  localparam int PW = lsm_pkg::PROD_W;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_CLEAR    = 9'b000000010,
    S_DISPATCH = 9'b000000100,
    S_LOOK     = 9'b000001000,
    S_FETCH    = 9'b000010000,
    S_MUL      = 9'b000100000,
    S_CHECK    = 9'b001000000,
    S_WAIT     = 9'b010000000,
    S_FINISH   = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  logic                      pend;
  logic [lsm_pkg::NUM_W-1:0] cur_number;
  logic [lsm_pkg::NUM_W-1:0] cur_top;
  lsm_pkg::kind_t            cur_kind;
  logic                      cur_prime;
  logic signed [1:0]         cur_mu;
  logic [PCW-1:0]            prime_count;
  logic [PCW-1:0]            k;
  logic [AW-1:0]             clr_addr;
  logic [PW-1:0]             prod;
  logic                      out_load;

  // composite bitmap
  logic          cmap [MAX_NUMBER];
  logic          cm_we;
  logic [AW-1:0] cm_wa;
  logic          cm_wd;
  logic [AW-1:0] cm_ra;
  logic          cm_rdata;

  // Moebius store
  logic signed [1:0] mob [MAX_NUMBER];
  logic              mob_we;
  logic [AW-1:0]     mob_wa;
  logic signed [1:0] mob_wd;
  logic [AW-1:0]     mob_ra;
  logic signed [1:0] mob_rdata;

  // prime list
  logic [lsm_pkg::NUM_W-1:0] plist [PRIME_SLOTS];
  logic                      pl_we;
  logic [PIW-1:0]            pl_wa;
  logic [PIW-1:0]            pl_ra;
  logic [lsm_pkg::NUM_W-1:0] pl_rdata;

  logic               rem_start;
  lsm_pkg::rem_stat_t rem_stat;

  lsm_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (cur_number),
    .divisor  (pl_rdata),
    .stat     (rem_stat)
  );

  assign clearing = state == S_CLEAR;

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    rem_start = 1'b0;
    out_load = 1'b0;
    cm_we = 1'b0;
    cm_wa = clr_addr;
    cm_wd = 1'b0;
    cm_ra = AW'(cur_number);
    mob_we = 1'b0;
    mob_wa = AW'(cur_number);
    mob_wd = lsm_pkg::MU_ZERO;
    mob_ra = AW'(cur_number);
    pl_we = 1'b0;
    pl_wa = prime_count[PIW-1:0];
    pl_ra = k[PIW-1:0];
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          state_next = q_item.clear ? S_CLEAR : S_DISPATCH;
        end
      end
      S_CLEAR: begin
        cm_we = 1'b1;
        if (clr_addr == AW'(MAX_NUMBER - 1)) begin
          state_next = pend ? S_DISPATCH : S_IDLE;
        end
      end
      S_DISPATCH: begin
        unique case (cur_kind)
          lsm_pkg::KIND_NUMBER: begin
            state_next = S_LOOK;
          end
          lsm_pkg::KIND_ONE: begin
            mob_we = 1'b1;
            mob_wd = lsm_pkg::MU_ONE;
            state_next = S_FINISH;
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_LOOK: begin
        // unmarked: a new prime, appended while the list has room
        if (!cm_rdata) begin
          mob_we = 1'b1;
          mob_wd = lsm_pkg::MU_MINUS_ONE;
          pl_we = prime_count < PCW'(PRIME_SLOTS);
        end
        state_next = S_FETCH;
      end
      S_FETCH: begin
        state_next = (k == prime_count) ? S_FINISH : S_MUL;
      end
      S_MUL: begin
        rem_start = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = (prod > PW'(cur_top)) ? S_FINISH : S_WAIT;
      end
      S_WAIT: begin
        if (rem_stat.done) begin
          cm_we = 1'b1;
          cm_wa = AW'(prod);
          cm_wd = 1'b1;
          mob_we = 1'b1;
          mob_wa = AW'(prod);
          mob_wd = rem_stat.divisible ? lsm_pkg::MU_ZERO : -cur_mu;
          state_next = rem_stat.divisible ? S_FINISH : S_FETCH;
        end
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      pend <= 1'b0;
      prime_count <= '0;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        pend <= q_item.clear;
        if (q_item.clear) begin
          prime_count <= '0;
          clr_addr <= '0;
        end
      end
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (pl_we) begin
        prime_count <= prime_count + PCW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_number <= q_item.number;
      cur_top <= q_item.top;
      cur_kind <= q_item.kind;
    end
    if (state == S_DISPATCH) begin
      cur_prime <= 1'b0;
      cur_mu <= lsm_pkg::MU_ONE;
    end
    if (state == S_LOOK) begin
      k <= '0;
      if (!cm_rdata) begin
        cur_prime <= 1'b1;
        cur_mu <= lsm_pkg::MU_MINUS_ONE;
      end else begin
        cur_mu <= mob_rdata;
      end
    end
    if (state == S_MUL) begin
      prod <= PW'(pl_rdata) * PW'(cur_number);
    end
    if (state == S_WAIT && rem_stat.done && !rem_stat.divisible) begin
      k <= k + PCW'(1);
    end
    if (out_load) begin
      if (cur_kind == lsm_pkg::KIND_DONE) begin
        number <= '0;
        is_prime <= 1'b0;
        mobius <= lsm_pkg::MU_ZERO;
        done_res <= 1'b1;
      end else begin
        number <= cur_number;
        is_prime <= cur_prime;
        mobius <= cur_mu;
        done_res <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cm_we) begin
      cmap[cm_wa] <= cm_wd;
    end
    cm_rdata <= cmap[cm_ra];
  end

  always_ff @(posedge clk) begin
    if (mob_we) begin
      mob[mob_wa] <= mob_wd;
    end
    mob_rdata <= mob[mob_ra];
  end

  always_ff @(posedge clk) begin
    if (pl_we) begin
      plist[pl_wa] <= cur_number;
    end
    pl_rdata <= plist[pl_ra];
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    prime_count <= PCW'(PRIME_SLOTS))
    else $error("prime count beyond list size");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_FETCH |-> k <= prime_count)
    else $error("prime walk ran past the list");

  a_mark_in_limit: assert property (@(posedge clk) disable iff (rst)
    (cm_we && cm_wd) |-> prod <= PW'(cur_top))
    else $error("composite mark beyond the limit");

  a_rem_restarted: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> !rem_stat.done)
    else $error("stale remainder status after start");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("result loaded outside finish");

endmodule

### rtl/core/linear_sieve_mobius.sv
// ----------------------------------------------------------------------------
// linear_sieve_mobius
// Linear sieve: primality and Moebius value of 1, 2, 3, ... up to a limit,
// one result beat per request beat.
// ----------------------------------------------------------------------------
//
//   channel  handshake                payload                         dir
//   -------  -----------------------  ------------------------------  ---
//   cfg      cfg_valid / cfg_ready    limit                           in
//   in       in_valid  / in_stall     restart                         in
//   out      out_valid / out_stall    number, is_prime, mobius,       out
//                                     done_res
//
// Flow: number one and beats beyond the limit go straight to the result
//   register; any other number looks itself up in the bitmap, then walks
//   the prime list, and for each prime whose multiple gets marked steps
//   through fetch, multiply, check and the bit-serial remainder unit. The
//   walk ends when the prime divides the number, when a multiple overshoots
//   the limit or when it runs off the end of the prime list.
// Reset: synchronous, active high; the composite bitmap is then swept, one
//   entry a cycle over all MAX_NUMBER entries, with in_stall high. A
//   restart beat runs the same sweep before number one is answered.
// Stalls: a two-deep queue parts front and engine, and the result register
//   parts the engine from out_stall, so requests are taken while a result
//   waits. Configuration is always ready.
//
module linear_sieve_mobius #(
  parameter int MAX_NUMBER  = lsm_pkg::MAX_NUMBER_DEF,
  parameter int PRIME_SLOTS = lsm_pkg::PRIME_SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lsm_pkg::NUM_W-1:0] limit,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      restart,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [lsm_pkg::NUM_W-1:0] number,
  output logic                      is_prime,
  output logic signed [1:0]         mobius,
  output logic                      done_res
);

  // front to queue
  logic           q_push;
  lsm_pkg::item_t q_in;
  // queue to engine
  logic           q_pop;
  lsm_pkg::item_t q_out;
  logic           q_full;
  logic           q_empty;
  // engine sweeping the bitmap: hold off requests
  logic           clearing;

  // Front: limit register, running number, classification of each beat
  lsm_front #(
    .MAX_NUMBER (MAX_NUMBER)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .limit     (limit),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .restart   (restart),
    .q_full    (q_full),
    .clearing  (clearing),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  lsm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .item_in  (q_in),
    .pop      (q_pop),
    .item_out (q_out),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Engine: memories, prime walk and result register
  lsm_back #(
    .MAX_NUMBER  (MAX_NUMBER),
    .PRIME_SLOTS (PRIME_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_item    (q_out),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .number    (number),
    .is_prime  (is_prime),
    .mobius    (mobius),
    .done_res  (done_res)
  );

endmodule

### verif/sieve_checker.sv
// ----------------------------------------------------------------------------
// sieve_checker
// Watches the config, request and result channels of linear_sieve_mobius.
// Keeps its own copy of the sieve, works out the answer for every accepted
// request beat and compares each result beat, field by field, with the
// oldest answer still due.
// ----------------------------------------------------------------------------
module sieve_checker
  import lsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [NUM_W-1:0]  limit,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              restart,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [NUM_W-1:0]  number,
  input  logic              is_prime,
  input  logic signed [1:0] mobius,
  input  logic              done_res,
  output int unsigned       outstanding,
  output int unsigned       errors
);

  localparam int SPAN      = MAX_NUMBER_DEF;
  localparam int SLOTS     = PRIME_SLOTS_DEF;

  typedef struct packed {
    logic [NUM_W-1:0]  number;
    logic              is_prime;
    logic signed [1:0] mu;
    logic              done;
  } answer_t;

  bit                composite [SPAN];
  logic signed [1:0] mu_table [SPAN];
  logic [NUM_W-1:0]  primes [SLOTS];
  int unsigned       prime_total;
  int unsigned       next_number;
  logic [NUM_W-1:0]  limit_shadow;
  answer_t           answers_due [$];

  task automatic flag(input string what);
    errors++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  task automatic wipe_sieve();
    for (int i = 0; i < SPAN; i++) composite[i] = 1'b0;
    prime_total = 0;
    next_number = 1;
  endtask

  // one request beat: the answer for the next number of the sieve
  task automatic predict_number(input logic fresh);
    int unsigned top;
    int unsigned n;
    int unsigned p;
    int unsigned m;
    answer_t     ans;
    top = limit_shadow;
    if (top > SPAN - 1) top = SPAN - 1;
    if (fresh) wipe_sieve();
    n = next_number;
    ans.number   = '0;
    ans.is_prime = 1'b0;
    ans.mu       = MU_ZERO;
    ans.done     = 1'b1;
    if (n <= top) begin
      if (n == 1) begin
        mu_table[1] = MU_ONE;
      end else begin
        if (!composite[n]) begin
          ans.is_prime = 1'b1;
          mu_table[n]  = MU_MINUS_ONE;
          if (prime_total < SLOTS) begin
            primes[prime_total] = NUM_W'(n);
            prime_total++;
          end
        end
        // each composite gets marked once, by its smallest prime factor
        for (int unsigned k = 0; k < prime_total; k++) begin
          p = primes[k];
          m = p * n;
          if (m > top) break;
          composite[m] = 1'b1;
          if (n % p == 0) begin
            mu_table[m] = MU_ZERO;
            break;
          end
          mu_table[m] = -mu_table[n];
        end
      end
      ans.number = NUM_W'(n);
      ans.mu     = mu_table[n];
      ans.done   = 1'b0;
      next_number = n + 1;
    end
    answers_due = {answers_due, ans};
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      wipe_sieve();
      limit_shadow = LIMIT_RESET;
      answers_due.delete();
      errors = 0;
    end else begin
      if (in_valid && !in_stall) predict_number(restart);
      if (cfg_valid && cfg_ready) limit_shadow = limit;
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          flag($sformatf("result beat (number %0d) with nothing due", number));
        end else begin
          want = answers_due.pop_front();
          if (number !== want.number)
            flag($sformatf("number %0d, want %0d", number, want.number));
          if (is_prime !== want.is_prime)
            flag($sformatf("is_prime %b for %0d, want %b", is_prime, want.number,
                           want.is_prime));
          if (mobius !== want.mu)
            flag($sformatf("mobius %0d for %0d, want %0d", mobius, want.number,
                           want.mu));
          if (done_res !== want.done)
            flag($sformatf("done_res %b for %0d, want %b", done_res, want.number,
                           want.done));
        end
      end
    end
    outstanding <= answers_due.size();
  end

endmodule

### verif/tb_linear_sieve_mobius.sv
// ----------------------------------------------------------------------------
// tb_linear_sieve_mobius
// Drives the sieve through a short directed run (number one, primes,
// squareful numbers, the done state, a limit raised without restart, a small
// and the largest limit) and then random phases, each with its own limit, mostly
// walking the sieve forward with the odd stray restart. sieve_checker does
// the prediction and comparison; this module only makes stimulus, idles
// both channels and gives the verdict.
// ----------------------------------------------------------------------------
module tb_linear_sieve_mobius;
  import lsm_pkg::*;

  localparam int ITEMS    = 2000;
  localparam int IDLE_PCT = 11;
  localparam int MAX_GAP  = 6;
  // Slowest sound run: the reset sweep plus well under 40 restart sweeps of
  // MAX_NUMBER entries, and ~2100 beats with gaps and stalls. About three
  // times that.
  localparam int CYCLE_LIMIT = 10_000_000;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [NUM_W-1:0]  limit     = '0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic              restart   = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [NUM_W-1:0]  number;
  logic              is_prime;
  logic signed [1:0] mobius;
  logic              done_res;

  // quiet: no idling on either side, for one long stretch
  logic              quiet     = 1'b0;
  int unsigned       outstanding;
  int unsigned       errors;
  int unsigned       sent;
  int unsigned       cycles;

  always #10 clk = ~clk;

  linear_sieve_mobius dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .limit     (limit),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .restart   (restart),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .number    (number),
    .is_prime  (is_prime),
    .mobius    (mobius),
    .done_res  (done_res)
  );

  sieve_checker sieve_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .limit       (limit),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .number      (number),
    .is_prime    (is_prime),
    .mobius      (mobius),
    .done_res    (done_res),
    .outstanding (outstanding),
    .errors      (errors)
  );

  // Result side: random stall, one cycle in ~9, held low in the quiet stretch.
  always @(posedge clk) begin
    if (rst || quiet) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // One request beat; may leave a random gap first. Valid stays up across
  // back-to-back beats.
  task automatic send_number(input logic rs);
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sent++;
  endtask

  // Hold off requests until every answer due has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Limit writes only ever happen with the block idle.
  task automatic set_limit(input logic [NUM_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    limit     <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned phase;
    int unsigned pick;
    int unsigned count;
    int unsigned new_limit;
    logic        fresh;
    phase = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // -- directed --
    // reset limit, no restart needed: 1, prime 2, 3, squareful 4, 5, 6 (mu +1)
    for (int i = 0; i < 6; i++) send_number(1'b0);
    // small limit: restart, 1, 2, then done twice (number must not move)
    set_limit(15'd2);
    send_number(1'b1);
    for (int i = 0; i < 3; i++) send_number(1'b0);
    // raise the limit without restart: 4 was skipped, so it shows as prime
    set_limit(15'd12);
    for (int i = 0; i < 11; i++) send_number(1'b0);
    // largest limit
    set_limit(NUM_W'(NUM_MAX));
    send_number(1'b1);
    send_number(1'b0);
    send_number(1'b0);

    // -- random phases --
    while (sent < ITEMS) begin
      phase++;
      quiet <= (phase == 2);
      pick = $urandom_range(99);
      if (phase == 2) begin
        new_limit = $urandom_range(1000, 3000);
        count     = 250;
      end else if (pick < 60) begin
        // small limit, walked through to done
        new_limit = $urandom_range(2, 300);
        count     = new_limit + $urandom_range(1, 4);
      end else if (pick < 85) begin
        new_limit = $urandom_range(301, 3000);
        count     = $urandom_range(100, 300);
      end else begin
        new_limit = (pick < 90) ? NUM_MAX : $urandom_range(3001, NUM_MAX);
        count     = $urandom_range(50, 200);
      end
      set_limit(NUM_W'(new_limit));
      // now and then carry on under the new limit without restarting
      fresh = ($urandom_range(3) != 0);
      for (int unsigned i = 0; i < count; i++)
        send_number((i == 0) ? fresh : ($urandom_range(399) == 0));
    end

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
